/* sv/bpu_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bpu_pkg: shared types and constants of the breakpoint unit
// Table size, field widths, command codes, status codes and the records
// passed between the controller and the row of table cells.
// ----------------------------------------------------------------------------
package bpu_pkg;

    localparam int MaxEntries = 16;                       // table depth, 1..16
    localparam int AddrW      = 16;
    localparam int IdxInW     = 4;                        // entry_index field
    localparam int IdxW       = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
    localparam int CntW       = $clog2(MaxEntries + 1);
    localparam int CmpW       = (IdxW > IdxInW) ? IdxW : IdxInW;
    localparam int CntOutW    = 5;

    typedef enum logic [2:0] {
        MODE_PC_CHECK  = 3'd0,
        MODE_ADD       = 3'd1,
        MODE_REMOVE    = 3'd2,
        MODE_CLEAR     = 3'd3,
        MODE_RESUME    = 3'd4,
        MODE_STEP      = 3'd5,
        MODE_BREAK_REQ = 3'd6,
        MODE_READ      = 3'd7
    } t_mode;

    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_FULL      = 3'd1,
        STAT_DUP       = 3'd2,
        STAT_NOT_FOUND = 3'd3,
        STAT_HELD      = 3'd4,
        STAT_BAD_INDEX = 3'd5
    } t_status;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic              op_add;
        logic              op_rem;
        logic [AddrW-1:0]  addr;
        logic [IdxInW-1:0] idx;
        logic [CntW-1:0]   count;
    } t_cmd;

    // handed from each cell to the next one up the row
    typedef struct packed {
        logic             hit;
        logic             rd_hit;
        logic [AddrW-1:0] rd_data;
    } t_link;

endpackage
`default_nettype wire

/* sv/bpu_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bpu_cell: one breakpoint table entry
// Holds one address, compares it against the broadcast address, and passes
// match and read data up the row; takes its upper neighbor's entry on remove.
// ----------------------------------------------------------------------------
module bpu_cell (
    input  wire logic                        i_clk,
    input  wire logic [bpu_pkg::IdxW-1:0]    i_pos,
    input  wire bpu_pkg::t_cmd               i_cmd,
    input  wire bpu_pkg::t_link              i_link,
    output bpu_pkg::t_link                   o_link,
    input  wire logic [bpu_pkg::AddrW-1:0]   i_next_entry,
    output logic [bpu_pkg::AddrW-1:0]        o_entry
);

    logic [bpu_pkg::AddrW-1:0] r_entry;
    logic [bpu_pkg::AddrW-1:0] n_entry;
    logic                      live;
    logic                      match;
    logic                      sel;
    logic                      at_tail;

    always_comb begin
        live    = bpu_pkg::CntW'(i_pos) < i_cmd.count;
        at_tail = bpu_pkg::CntW'(i_pos) == i_cmd.count;
        match   = live && (r_entry == i_cmd.addr);
        sel     = live && (bpu_pkg::CmpW'(i_pos) == bpu_pkg::CmpW'(i_cmd.idx));

        o_link.hit     = i_link.hit | match;
        o_link.rd_hit  = i_link.rd_hit | sel;
        o_link.rd_data = sel ? r_entry : i_link.rd_data;

        // at or above the removed entry: close the gap
        priority if (i_cmd.op_rem && o_link.hit) begin
            n_entry = i_next_entry;
        end else if (i_cmd.op_add && at_tail) begin
            n_entry = i_cmd.addr;
        end else begin
            n_entry = r_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule
`default_nettype wire

/* sv/breakpoint_unit_with_halt_control.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// breakpoint_unit_with_halt_control: CPU debug breakpoint unit
// Breakpoint table built as a row of cells, plus halt and break-next control.
// ----------------------------------------------------------------------------
// Usage:
//   A command transaction is taken at a rising edge with start high and busy
//   low: i_mode selects pc_check, add, remove, clear, resume, step,
//   break_request or read_entry; i_address carries the PC or breakpoint
//   address, i_entry_index the table slot for read_entry.
//   Every command gives exactly one result transaction: o_done is high for
//   one cycle with o_status, o_break_taken, o_halted, o_entry_count and
//   o_entry_value valid. The receiver cannot stall; the result is gone after
//   that cycle.
//   The command is registered at accept, executed in the following
//   cycle (busy high) and the result is shown in the cycle after that.
//   The execute cycle is where the
//   address is broadcast to all table cells and the match/read chain ripples
//   through the row; a new command can be taken while a result is shown, but not while one executes.
//   Reset (synchronous, active low) empties the table, clears halt and
//   break-next. Table contents are not cleared; slots above the count are
//   never observed.
// ----------------------------------------------------------------------------
module breakpoint_unit_with_halt_control (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [2:0]                     i_mode,
    input  wire logic [bpu_pkg::AddrW-1:0]      i_address,
    input  wire logic [bpu_pkg::IdxInW-1:0]     i_entry_index,
    output logic                                o_done,
    output logic [2:0]                          o_status,
    output logic                                o_break_taken,
    output logic                                o_halted,
    output logic [bpu_pkg::CntOutW-1:0]         o_entry_count,
    output logic [bpu_pkg::AddrW-1:0]           o_entry_value
);

    // control state
    bpu_pkg::t_state r_state, n_state;
    logic [bpu_pkg::CntW-1:0] r_count, n_count;
    logic r_halt, n_halt;
    logic r_brk_next, n_brk_next;
    logic r_done, n_done;

    // captured command (payload)
    bpu_pkg::t_mode r_mode;
    logic [bpu_pkg::AddrW-1:0]  r_addr;
    logic [bpu_pkg::IdxInW-1:0] r_idx;

    // result registers (payload)
    bpu_pkg::t_status r_status, n_status;
    logic r_taken, n_taken;
    logic [bpu_pkg::AddrW-1:0] r_value, n_value;

    logic accept;
    logic exec;
    logic found;
    logic full;
    bpu_pkg::t_cmd cmd;

    bpu_pkg::t_link            link  [bpu_pkg::MaxEntries+1];
    logic [bpu_pkg::AddrW-1:0] entry [bpu_pkg::MaxEntries+1];

    assign accept = start && !busy;
    assign exec   = (r_state == bpu_pkg::ST_EXEC);
    assign busy   = exec;

    // broadcast to the row; table writes only in the execute cycle
    always_comb begin
        cmd.op_add = exec && (r_mode == bpu_pkg::MODE_ADD);
        cmd.op_rem = exec && (r_mode == bpu_pkg::MODE_REMOVE);
        cmd.addr   = r_addr;
        cmd.idx    = r_idx;
        cmd.count  = r_count;
    end

    // ends of the chain: nothing below the first cell, nothing above the last
    assign link[0]                    = '0;
    assign entry[bpu_pkg::MaxEntries] = '0;

    for (genvar g = 0; g < bpu_pkg::MaxEntries; g++) begin : g_cell
        bpu_cell u_cell (
            .i_clk        (i_clk),
            .i_pos        (bpu_pkg::IdxW'(g)),
            .i_cmd        (cmd),
            .i_link       (link[g]),
            .o_link       (link[g+1]),
            .i_next_entry (entry[g+1]),
            .o_entry      (entry[g])
        );
    end

    assign found = link[bpu_pkg::MaxEntries].hit;
    assign full  = (r_count >= bpu_pkg::CntW'(bpu_pkg::MaxEntries));

    // next state and command execution
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_halt     = r_halt;
        n_brk_next = r_brk_next;
        n_done     = 1'b0;
        n_status   = bpu_pkg::STAT_OK;
        n_taken    = 1'b0;
        n_value    = '0;

        unique case (r_state)
            bpu_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = bpu_pkg::ST_EXEC;
                end
            end
            bpu_pkg::ST_EXEC: begin
                n_state = bpu_pkg::ST_IDLE;
                n_done  = 1'b1;
                unique case (r_mode)
                    bpu_pkg::MODE_PC_CHECK: begin
                        priority if (r_halt) begin
                            n_status = bpu_pkg::STAT_HELD;
                        end else if (r_brk_next) begin
                            n_brk_next = 1'b0;
                            n_halt     = 1'b1;
                            n_taken    = 1'b1;
                        end else if (found) begin
                            n_halt  = 1'b1;
                            n_taken = 1'b1;
                        end
                    end
                    bpu_pkg::MODE_ADD: begin
                        // fullness takes precedence over duplicates
                        priority if (full) begin
                            n_status = bpu_pkg::STAT_FULL;
                        end else if (found) begin
                            n_status = bpu_pkg::STAT_DUP;
                        end else begin
                            n_count = r_count + 1'b1;
                        end
                    end
                    bpu_pkg::MODE_REMOVE: begin
                        if (found) begin
                            n_count = r_count - 1'b1;
                        end else begin
                            n_status = bpu_pkg::STAT_NOT_FOUND;
                        end
                    end
                    bpu_pkg::MODE_CLEAR: begin
                        n_count = '0;
                    end
                    bpu_pkg::MODE_RESUME: begin
                        n_halt = 1'b0;
                    end
                    bpu_pkg::MODE_STEP: begin
                        if (r_halt) begin
                            n_brk_next = 1'b1;
                            n_halt     = 1'b0;
                        end
                    end
                    bpu_pkg::MODE_BREAK_REQ: begin
                        if (!r_halt) begin
                            n_brk_next = 1'b1;
                        end
                    end
                    bpu_pkg::MODE_READ: begin
                        if (link[bpu_pkg::MaxEntries].rd_hit) begin
                            n_value = link[bpu_pkg::MaxEntries].rd_data;
                        end else begin
                            n_status = bpu_pkg::STAT_BAD_INDEX;
                        end
                    end
                endcase
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= bpu_pkg::ST_IDLE;
            r_count    <= '0;
            r_halt     <= 1'b0;
            r_brk_next <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_halt     <= n_halt;
            r_brk_next <= n_brk_next;
            r_done     <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode <= bpu_pkg::t_mode'(i_mode);
            r_addr <= i_address;
            r_idx  <= i_entry_index;
        end
        if (exec) begin
            r_status <= n_status;
            r_taken  <= n_taken;
            r_value  <= n_value;
        end
    end

    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_break_taken = r_taken;
    assign o_halted      = r_halt;
    assign o_entry_count = bpu_pkg::CntOutW'(r_count);
    assign o_entry_value = r_value;

    // every execute cycle produces exactly one result strobe
    a_exec_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec |=> r_done)
        else $error("execute cycle not followed by result strobe");

    // results never come back to back
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("result strobe held for two cycles");

    // count never exceeds table depth
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= bpu_pkg::CntW'(bpu_pkg::MaxEntries))
        else $error("entry count beyond table depth");

    // a taken break always leaves the CPU halted
    a_taken_halt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_break_taken) |-> o_halted)
        else $error("break taken without halt");

    // when break-next arms, the CPU is running
    a_brk_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_brk_next) |-> !r_halt)
        else $error("break-next armed while halted");

endmodule
`default_nettype wire
